// ===== hdl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int NUM_CFG   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef logic [CFG_W-1:0] cfg_word_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUF    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SU_STA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HD_STA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SU_STO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SU_DAT = 3'd6;

    localparam cfg_word_t CFG_RESET [NUM_CFG] = '{
        16'd5, 16'd5, 16'd4, 16'd4, 16'd4, 16'd5, 16'd1
    };

    // command codes
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // write modes; for reads any nonzero mode sends nack
    localparam logic [1:0] MODE_RAW    = 2'd0;
    localparam logic [1:0] MODE_ADDR_W = 2'd1;
    localparam logic [1:0] MODE_ADDR_R = 2'd2;

    localparam logic [7:0] ADDR_W_MASK = 8'hFE;
    localparam logic [7:0] ADDR_R_BIT  = 8'h01;

    localparam logic [3:0] LAST_DATA_BIT = 4'd8;
    localparam logic [3:0] BITS_PER_BYTE = 4'd9;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_BUF,
        PH_ST_SU,
        PH_ST_HD,
        PH_SP_PREP,
        PH_SP_SU,
        PH_WR_SU,
        PH_WR_HI,
        PH_WR_LO,
        PH_RD_SU,
        PH_RD_HI,
        PH_RD_LO
    } phase_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       ack;
        logic       rejected;
    } i2cm_result_t;

endpackage

// ===== hdl/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Bit-banged I2C master: start, stop, write byte and read byte on tick items.
// ----------------------------------------------------------------------------
// Usage:
// - in channel (in_valid/in_ready) carries one tick or command per request;
//   func selects tick, start, stop, write or read, data/mode/sda_in go along.
// - out channel (out_valid/out_ready) returns one result per request: the
//   SCL/SDA levels to drive, busy, a done pulse, the last read byte, the last
//   write ack and a flag for a command given while busy.
// - cfg channel (cfg_valid/cfg_ready, always ready) writes the seven tick
//   count registers; cfg_index 7 is ignored. Write only while idle.
// - a request is taken into the input register, then the sequencer step runs
//   combinationally into the result register, which raises out_valid; a
//   held result stalls the step.
// - throughput: one request per cycle while out_ready stays high, as the
//   step from the input register to the result register is combinational.
// - when out_ready is low the result register holds, the input register
//   keeps one more request and in_ready drops until the result is taken.
// - reset: timing registers go to their defaults, the sequencer is idle with
//   both lines released, and no request or result is pending.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
    parameter int TIMER_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     func,
    input  logic [7:0]                     data,
    input  logic [1:0]                     mode,
    input  logic                           sda_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           scl_out,
    output logic                           sda_release,
    output logic                           busy_res,
    output logic                           done_res,
    output logic [7:0]                     read_data,
    output logic                           ack_received,
    output logic                           rejected,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [i2cm_pkg::CFG_W-1:0]     cfg_data
);
    import i2cm_pkg::*;

    logic         in_valid_reg;
    logic [2:0]   func_reg;
    logic [7:0]   data_reg;
    logic [1:0]   mode_reg;
    logic         sda_in_reg;
    logic         advance;
    cfg_word_t    cfg_regs [NUM_CFG];
    i2cm_result_t result_next;
    i2cm_result_t result_reg;
    logic         out_valid_reg;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg   <= func;
            data_reg   <= data;
            mode_reg   <= mode;
            sda_in_reg <= sda_in;
        end
    end

    i2cm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg_regs (cfg_regs)
    );

    i2cm_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .func        (func_reg),
        .data        (data_reg),
        .mode        (mode_reg),
        .sda_in      (sda_in_reg),
        .cfg_regs    (cfg_regs),
        .result_next (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_out      = result_reg.scl;
    assign sda_release  = result_reg.sda;
    assign busy_res     = result_reg.busy;
    assign done_res     = result_reg.done;
    assign read_data    = result_reg.read_data;
    assign ack_received = result_reg.ack;
    assign rejected     = result_reg.rejected;

`ifndef ASSERT_OFF
    // a finished command leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done result while still busy");

    // a rejected command never completes anything
    a_rej_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> !done_res && busy_res)
        else $error("rejected result with done or idle");

    // the input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid && !out_ready)
        else $error("input stalled without a held result");

    // a held result stays put while the receiver stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_reg))
        else $error("result changed under stall");
`endif

endmodule

// ===== hdl/i2cm_cfg.sv =====
// ----------------------------------------------------------------------------
// i2cm_cfg
// Timing register file, loaded with default tick counts at reset.
// ----------------------------------------------------------------------------
module i2cm_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] wr_index,
    input  i2cm_pkg::cfg_word_t          wr_data,
    output i2cm_pkg::cfg_word_t          cfg_regs [i2cm_pkg::NUM_CFG]
);
    import i2cm_pkg::*;

    cfg_word_t cfg_reg [NUM_CFG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (wr_en && (wr_index < CFG_IDX_W'(NUM_CFG)))
        begin
            cfg_reg[wr_index] <= wr_data;
        end
    end

    assign cfg_regs = cfg_reg;

endmodule

// ===== hdl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: phase state, tick timer, bit counter and shift register.
// ----------------------------------------------------------------------------
module i2cm_engine #(
    parameter int TIMER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [2:0]             func,
    input  logic [7:0]             data,
    input  logic [1:0]             mode,
    input  logic                   sda_in,
    input  i2cm_pkg::cfg_word_t    cfg_regs [i2cm_pkg::NUM_CFG],
    output i2cm_pkg::i2cm_result_t result_next
);
    import i2cm_pkg::*;

    localparam int WIDE_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [WIDE_W-1:0] TIMER_MAX = WIDE_W'({TIMER_BITS{1'b1}});

    phase_t                phase_reg, phase_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [7:0]            shifter_reg, shifter_next;
    logic                  ack_choice_reg, ack_choice_next;
    logic [7:0]            read_byte_reg, read_byte_next;
    logic                  ack_status_reg, ack_status_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;

    logic                  busy;
    logic [TIMER_BITS-1:0] timer_dec;
    logic                  expire;
    logic [3:0]            bit_inc;
    logic [7:0]            wr_byte;
    logic                  load_en;
    logic [CFG_IDX_W-1:0]  load_sel;
    logic [WIDE_W-1:0]     load_wide;
    logic [TIMER_BITS-1:0] load_ticks;
    logic                  done;
    logic                  rej;

    assign busy      = (phase_reg != PH_IDLE);
    assign timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : '0;
    assign expire    = (timer_dec == '0);
    assign bit_inc   = bit_count_reg + 4'd1;

    always_comb
    begin
        case (mode)
            MODE_ADDR_W: wr_byte = {data[6:0], 1'b0} & ADDR_W_MASK;
            MODE_ADDR_R: wr_byte = {data[6:0], 1'b0} | ADDR_R_BIT;
            default:     wr_byte = data;
        endcase
    end

    // zero counts as one, counts beyond the timer range saturate
    assign load_wide  = WIDE_W'(cfg_regs[load_sel]);
    assign load_ticks = (load_wide == '0) ? TIMER_BITS'(1) :
                        (load_wide > TIMER_MAX) ? TIMER_BITS'(TIMER_MAX) :
                        TIMER_BITS'(load_wide);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (func)
            FUNC_TICK:
            begin
                if (busy && expire)
                begin
                    case (phase_reg)
                        PH_ST_BUF:  phase_next = PH_ST_SU;
                        PH_ST_SU:   phase_next = PH_ST_HD;
                        PH_SP_PREP: phase_next = PH_SP_SU;
                        PH_WR_SU:   phase_next = PH_WR_HI;
                        PH_WR_HI:   phase_next = PH_WR_LO;
                        PH_WR_LO:
                            phase_next = (bit_inc >= BITS_PER_BYTE) ? PH_IDLE : PH_WR_SU;
                        PH_RD_SU:   phase_next = PH_RD_HI;
                        PH_RD_HI:   phase_next = PH_RD_LO;
                        PH_RD_LO:
                            phase_next = (bit_inc >= BITS_PER_BYTE) ? PH_IDLE : PH_RD_SU;
                        default:    phase_next = PH_IDLE;
                    endcase
                end
            end
            FUNC_START: if (!busy) phase_next = PH_ST_BUF;
            FUNC_STOP:  if (!busy) phase_next = PH_SP_PREP;
            FUNC_WRITE: if (!busy) phase_next = PH_WR_SU;
            FUNC_READ:  if (!busy) phase_next = PH_RD_SU;
            default:    phase_next = phase_reg;
        endcase
    end

    // datapath and line levels
    always_comb
    begin
        bit_count_next  = bit_count_reg;
        timer_next      = timer_reg;
        shifter_next    = shifter_reg;
        ack_choice_next = ack_choice_reg;
        read_byte_next  = read_byte_reg;
        ack_status_next = ack_status_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        load_en         = 1'b0;
        load_sel        = CFG_BUF;
        done            = 1'b0;
        rej             = 1'b0;
        case (func)
            FUNC_TICK:
            begin
                if (busy)
                begin
                    timer_next = timer_dec;
                    if (expire)
                    begin
                        case (phase_reg)
                            PH_ST_BUF:
                            begin
                                load_en  = 1'b1;
                                load_sel = CFG_SU_STA;
                            end
                            PH_ST_SU:
                            begin
                                sda_next = 1'b0;
                                load_en  = 1'b1;
                                load_sel = CFG_HD_STA;
                            end
                            PH_ST_HD:
                            begin
                                scl_next = 1'b0;
                                done     = 1'b1;
                            end
                            PH_SP_PREP:
                            begin
                                scl_next = 1'b1;
                                load_en  = 1'b1;
                                load_sel = CFG_SU_STO;
                            end
                            PH_SP_SU:
                            begin
                                sda_next = 1'b1;
                                done     = 1'b1;
                            end
                            PH_WR_SU, PH_RD_SU:
                            begin
                                scl_next = 1'b1;
                                load_en  = 1'b1;
                                load_sel = CFG_HIGH;
                            end
                            PH_WR_HI:
                            begin
                                // ack bit sampled at the end of the ninth high phase
                                if (bit_count_reg == LAST_DATA_BIT)
                                begin
                                    ack_status_next = sda_in;
                                end
                                scl_next = 1'b0;
                                load_en  = 1'b1;
                                load_sel = CFG_LOW;
                            end
                            PH_RD_HI:
                            begin
                                if (bit_count_reg < LAST_DATA_BIT)
                                begin
                                    shifter_next = {shifter_reg[6:0], sda_in};
                                end
                                scl_next = 1'b0;
                                load_en  = 1'b1;
                                load_sel = CFG_LOW;
                            end
                            PH_WR_LO:
                            begin
                                bit_count_next = bit_inc;
                                if (bit_inc >= BITS_PER_BYTE)
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    if (bit_inc < LAST_DATA_BIT)
                                    begin
                                        sda_next = shifter_reg[3'(4'd7 - bit_inc)];
                                    end
                                    else
                                    begin
                                        sda_next = 1'b1;
                                    end
                                    load_en  = 1'b1;
                                    load_sel = CFG_SU_DAT;
                                end
                            end
                            PH_RD_LO:
                            begin
                                bit_count_next = bit_inc;
                                if (bit_inc >= BITS_PER_BYTE)
                                begin
                                    read_byte_next = shifter_reg;
                                    done           = 1'b1;
                                end
                                else
                                begin
                                    sda_next = (bit_inc == LAST_DATA_BIT) ? ack_choice_reg : 1'b1;
                                    load_en  = 1'b1;
                                    load_sel = CFG_SU_DAT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            FUNC_START:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    load_en  = 1'b1;
                    load_sel = CFG_BUF;
                end
            end
            FUNC_STOP:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    sda_next = 1'b0;
                    load_en  = 1'b1;
                    load_sel = CFG_SU_DAT;
                end
            end
            FUNC_WRITE:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    shifter_next   = wr_byte;
                    bit_count_next = 4'd0;
                    scl_next       = 1'b0;
                    sda_next       = wr_byte[7];
                    load_en        = 1'b1;
                    load_sel       = CFG_SU_DAT;
                end
            end
            FUNC_READ:
            begin
                if (busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    ack_choice_next = (mode != MODE_RAW);
                    shifter_next    = 8'd0;
                    bit_count_next  = 4'd0;
                    scl_next        = 1'b0;
                    sda_next        = 1'b1;
                    load_en         = 1'b1;
                    load_sel        = CFG_SU_DAT;
                end
            end
            default: ;
        endcase
        if (load_en)
        begin
            timer_next = load_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            timer_reg      <= '0;
            shifter_reg    <= 8'd0;
            ack_choice_reg <= 1'b0;
            read_byte_reg  <= 8'd0;
            ack_status_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            timer_reg      <= timer_next;
            shifter_reg    <= shifter_next;
            ack_choice_reg <= ack_choice_next;
            read_byte_reg  <= read_byte_next;
            ack_status_reg <= ack_status_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
        end
    end

    assign result_next.scl       = scl_next;
    assign result_next.sda       = sda_next;
    assign result_next.busy      = (phase_next != PH_IDLE);
    assign result_next.done      = done;
    assign result_next.read_data = read_byte_next;
    assign result_next.ack       = ack_status_next;
    assign result_next.rejected  = rej;

endmodule

// ===== bench/tb_i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine
// Checks the I2C master byte engine against a tick-level model of its bus
// sequencer. Every accepted request is run through the model, and each result
// the block returns is compared field by field with the oldest prediction.
// Directed commands come first. Random start/address/data/stop transfers
// follow, with noise and cut-short commands mixed in. The timing registers
// are reloaded between phases; both handshakes idle at random but in the last.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;

    import i2cm_pkg::*;

    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    typedef enum int {
        PROF_ZERO,
        PROF_MIN,
        PROF_LONG_BUS,
        PROF_SMALL
    } cfg_profile_t;

    typedef struct {
        logic [2:0] func;
        logic [7:0] data;
        logic [1:0] mode;
        logic       sda;
    } bus_cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [2:0]           func = FUNC_TICK;
    logic [7:0]           data = 8'h00;
    logic [1:0]           mode = MODE_RAW;
    logic                 sda_in = 1'b1;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 scl_out;
    logic                 sda_release;
    logic                 busy_res;
    logic                 done_res;
    logic [7:0]           read_data;
    logic                 ack_received;
    logic                 rejected;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BUF;
    logic [CFG_W-1:0]     cfg_data = '0;

    bus_cmd_t     cmd_queue[$];
    bus_cmd_t     next_cmd;
    i2cm_result_t predicted_bus[$];
    i2cm_result_t want;
    int           errors = 0;
    int           in_gap = 0;
    int           out_gap = 0;
    logic         no_idle = 1'b0;

    // model of the sequencer
    cfg_word_t  cfg_now [NUM_CFG];
    phase_t     m_phase = PH_IDLE;
    logic [3:0] m_bits = '0;
    logic [15:0] m_timer = '0;
    logic [7:0] m_shift = '0;
    logic       m_ack_choice = 1'b0;
    logic [7:0] m_read = '0;
    logic       m_ack = 1'b0;
    logic       m_scl = 1'b1;
    logic       m_sda = 1'b1;

    i2c_master_byte_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .data         (data),
        .mode         (mode),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_out      (scl_out),
        .sda_release  (sda_release),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_data    (read_data),
        .ack_received (ack_received),
        .rejected     (rejected),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // a zero count behaves as one tick
    function automatic int ticks_of(input logic [CFG_IDX_W-1:0] idx);
        return (cfg_now[idx] == '0) ? 1 : int'(cfg_now[idx]);
    endfunction

    function automatic void load_phase(input phase_t ph, input logic [CFG_IDX_W-1:0] idx);
        m_phase = ph;
        m_timer = 16'(ticks_of(idx));
    endfunction

    function automatic i2cm_result_t bus_step(input logic [2:0] f, input logic [7:0] d,
                                              input logic [1:0] m, input logic s);
        i2cm_result_t r;
        logic         fin;
        logic         rej;
        fin = 1'b0;
        rej = 1'b0;
        if (f == FUNC_TICK) begin
            if (m_phase != PH_IDLE) begin
                if (m_timer != '0)
                    m_timer = m_timer - 16'd1;
                if (m_timer == '0) begin
                    case (m_phase)
                        PH_ST_BUF:
                            load_phase(PH_ST_SU, CFG_SU_STA);
                        PH_ST_SU:
                        begin
                            m_sda = 1'b0;
                            load_phase(PH_ST_HD, CFG_HD_STA);
                        end
                        PH_ST_HD:
                        begin
                            m_scl = 1'b0;
                            m_phase = PH_IDLE;
                            fin = 1'b1;
                        end
                        PH_SP_PREP:
                        begin
                            m_scl = 1'b1;
                            load_phase(PH_SP_SU, CFG_SU_STO);
                        end
                        PH_SP_SU:
                        begin
                            m_sda = 1'b1;
                            m_phase = PH_IDLE;
                            fin = 1'b1;
                        end
                        PH_WR_SU:
                        begin
                            m_scl = 1'b1;
                            load_phase(PH_WR_HI, CFG_HIGH);
                        end
                        PH_WR_HI:
                        begin
                            // slave answer is sampled at the end of the ninth high phase
                            if (m_bits == LAST_DATA_BIT)
                                m_ack = s;
                            m_scl = 1'b0;
                            load_phase(PH_WR_LO, CFG_LOW);
                        end
                        PH_WR_LO:
                        begin
                            m_bits = m_bits + 4'd1;
                            if (m_bits >= BITS_PER_BYTE) begin
                                m_phase = PH_IDLE;
                                fin = 1'b1;
                            end
                            else begin
                                if (m_bits < LAST_DATA_BIT)
                                    m_sda = m_shift[7 - m_bits];
                                else
                                    m_sda = 1'b1;
                                load_phase(PH_WR_SU, CFG_SU_DAT);
                            end
                        end
                        PH_RD_SU:
                        begin
                            m_scl = 1'b1;
                            load_phase(PH_RD_HI, CFG_HIGH);
                        end
                        PH_RD_HI:
                        begin
                            if (m_bits < LAST_DATA_BIT)
                                m_shift = {m_shift[6:0], s};
                            m_scl = 1'b0;
                            load_phase(PH_RD_LO, CFG_LOW);
                        end
                        PH_RD_LO:
                        begin
                            m_bits = m_bits + 4'd1;
                            if (m_bits >= BITS_PER_BYTE) begin
                                m_read = m_shift;
                                m_phase = PH_IDLE;
                                fin = 1'b1;
                            end
                            else begin
                                m_sda = (m_bits == LAST_DATA_BIT) ? m_ack_choice : 1'b1;
                                load_phase(PH_RD_SU, CFG_SU_DAT);
                            end
                        end
                        default:
                            m_phase = PH_IDLE;
                    endcase
                end
            end
        end
        else if (f <= FUNC_READ) begin
            if (m_phase != PH_IDLE) begin
                rej = 1'b1;
            end
            else begin
                case (f)
                    FUNC_START:
                    begin
                        m_scl = 1'b1;
                        m_sda = 1'b1;
                        load_phase(PH_ST_BUF, CFG_BUF);
                    end
                    FUNC_STOP:
                    begin
                        m_sda = 1'b0;
                        load_phase(PH_SP_PREP, CFG_SU_DAT);
                    end
                    FUNC_WRITE:
                    begin
                        case (m)
                            MODE_ADDR_W: m_shift = (d << 1) & ADDR_W_MASK;
                            MODE_ADDR_R: m_shift = (d << 1) | ADDR_R_BIT;
                            default:     m_shift = d;
                        endcase
                        m_bits = '0;
                        m_scl = 1'b0;
                        m_sda = m_shift[7];
                        load_phase(PH_WR_SU, CFG_SU_DAT);
                    end
                    default:
                    begin
                        m_ack_choice = (m != MODE_RAW);
                        m_shift = '0;
                        m_bits = '0;
                        m_scl = 1'b0;
                        m_sda = 1'b1;
                        load_phase(PH_RD_SU, CFG_SU_DAT);
                    end
                endcase
            end
        end
        r.scl       = m_scl;
        r.sda       = m_sda;
        r.busy      = (m_phase != PH_IDLE);
        r.done      = fin;
        r.read_data = m_read;
        r.ack       = m_ack;
        r.rejected  = rej;
        return r;
    endfunction

    // request driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                predicted_bus.push_back(bus_step(func, data, mode, sda_in));
            if (in_valid && !in_ready) begin
                // hold the request until taken
            end
            else if (in_gap != 0) begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (cmd_queue.size() != 0) begin
                next_cmd = cmd_queue.pop_front();
                in_valid <= 1'b1;
                func <= next_cmd.func;
                data <= next_cmd.data;
                mode <= next_cmd.mode;
                sda_in <= next_cmd.sda;
                if (!no_idle && $urandom_range(0, 7) == 0)
                    in_gap <= $urandom_range(1, 4);
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (predicted_bus.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual scl=%b sda=%b busy=%b",
                             $time, scl_out, sda_release, busy_res);
                    errors++;
                end
                else begin
                    want = predicted_bus.pop_front();
                    check_field("scl_out", want.scl, scl_out);
                    check_field("sda_release", want.sda, sda_release);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("done_res", want.done, done_res);
                    check_field("read_data", want.read_data, read_data);
                    check_field("ack_received", want.ack, ack_received);
                    check_field("rejected", want.rejected, rejected);
                end
            end
            if (out_gap != 0) begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0) begin
                out_gap <= $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic int cmd_ticks(input logic [2:0] f);
        case (f)
            FUNC_START:
                return ticks_of(CFG_BUF) + ticks_of(CFG_SU_STA) + ticks_of(CFG_HD_STA);
            FUNC_STOP:
                return ticks_of(CFG_SU_DAT) + ticks_of(CFG_SU_STO);
            FUNC_WRITE, FUNC_READ:
                return int'(BITS_PER_BYTE)
                       * (ticks_of(CFG_SU_DAT) + ticks_of(CFG_HIGH) + ticks_of(CFG_LOW));
            default:
                return 0;
        endcase
    endfunction

    function automatic logic pick_sda(input int sel);
        if (sel == SDA_RANDOM)
            return 1'($urandom_range(0, 1));
        return (sel == SDA_HIGH);
    endfunction

    task automatic push_request(input logic [2:0] f, input logic [7:0] d,
                                input logic [1:0] m, input int sel);
        bus_cmd_t c;
        c.func = f;
        c.data = d;
        c.mode = m;
        c.sda = pick_sda(sel);
        cmd_queue.push_back(c);
    endtask

    task automatic push_ticks(input int n, input int sel);
        int i;
        for (i = 0; i < n; i++)
            push_request(FUNC_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), sel);
    endtask

    // a command followed by the ticks it needs, less trim
    task automatic push_cmd(input logic [2:0] f, input logic [7:0] d, input logic [1:0] m,
                            input int sel, input int trim);
        int n;
        n = cmd_ticks(f) - trim;
        push_request(f, d, m, sel);
        push_ticks((n < 0) ? 0 : n, sel);
    endtask

    task automatic push_traffic(input int budget);
        int   stop_at;
        int   n;
        int   k;
        int   trim;
        logic rd;
        logic [2:0] f;
        stop_at = cmd_queue.size() + budget;
        while (cmd_queue.size() < stop_at) begin
            if ($urandom_range(0, 4) != 0) begin
                rd = 1'($urandom_range(0, 1));
                push_cmd(FUNC_START, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                         SDA_RANDOM, 0);
                push_cmd(FUNC_WRITE, 8'($urandom_range(0, 255)),
                         rd ? MODE_ADDR_R : MODE_ADDR_W, SDA_RANDOM, 0);
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++) begin
                    // now and then a command is cut short so the next one collides
                    trim = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
                    push_cmd(rd ? FUNC_READ : FUNC_WRITE, 8'($urandom_range(0, 255)),
                             2'($urandom_range(0, 3)), SDA_RANDOM, trim);
                end
                push_cmd(FUNC_STOP, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                         SDA_RANDOM, 0);
            end
            else begin
                f = 3'($urandom_range(0, 7));
                push_request(f, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                             SDA_RANDOM);
                push_ticks($urandom_range(0, cmd_ticks(f) + 2), SDA_RANDOM);
            end
        end
        // let any unfinished command run out before the next register load
        push_ticks(cmd_ticks(FUNC_START) + cmd_ticks(FUNC_WRITE), SDA_RANDOM);
    endtask

    // wait for every request to be taken and every result to come back
    task automatic settle();
        int n;
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || in_valid);
        n = 0;
        while (predicted_bus.size() != 0 && n < 200) begin
            @(negedge clk);
            n++;
        end
        if (predicted_bus.size() != 0) begin
            $display("%0t: expected %0d more results, actual none", $time,
                     predicted_bus.size());
            errors++;
            predicted_bus.delete();
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input int idx, input cfg_word_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx[CFG_IDX_W-1:0];
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_now[idx] = val;
    endtask

    function automatic cfg_word_t pick_cfg(input cfg_profile_t prof, input int idx);
        case (prof)
            PROF_ZERO:     return '0;
            PROF_MIN:      return 16'd1;
            PROF_LONG_BUS: return (idx == int'(CFG_BUF)) ? 16'd64 : 16'd1;
            default:       return cfg_word_t'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic run_phase(input cfg_profile_t prof, input int budget);
        int i;
        @(posedge clk);
        for (i = 0; i < NUM_CFG; i++)
            write_reg(i, pick_cfg(prof, i));
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (prof == PROF_LONG_BUS) begin
            push_cmd(FUNC_START, 8'h00, MODE_RAW, SDA_RANDOM, 0);
            push_cmd(FUNC_WRITE, 8'($urandom_range(0, 255)), MODE_ADDR_W, SDA_LOW, 0);
            push_cmd(FUNC_STOP, 8'h00, MODE_RAW, SDA_RANDOM, 0);
        end
        else begin
            push_traffic(budget);
        end
        settle();
    endtask

    initial begin
        for (int i = 0; i < NUM_CFG; i++)
            cfg_now[i] = CFG_RESET[i];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at the reset timing
        push_request(FUNC_TICK, 8'hFF, 2'd3, SDA_LOW);
        push_request(3'd5, 8'h00, MODE_RAW, SDA_HIGH);
        push_request(3'd6, 8'hFF, 2'd3, SDA_LOW);
        push_request(3'd7, 8'h55, MODE_ADDR_W, SDA_HIGH);
        // stop with no start before it
        push_cmd(FUNC_STOP, 8'h00, MODE_RAW, SDA_RANDOM, 0);
        // start, then every command while busy
        push_request(FUNC_START, 8'h00, MODE_RAW, SDA_HIGH);
        push_request(FUNC_START, 8'h00, MODE_RAW, SDA_HIGH);
        push_request(FUNC_STOP, 8'h00, MODE_RAW, SDA_HIGH);
        push_request(FUNC_WRITE, 8'hAA, MODE_RAW, SDA_HIGH);
        push_request(FUNC_READ, 8'h00, MODE_ADDR_W, SDA_HIGH);
        push_request(3'd7, 8'h00, MODE_RAW, SDA_HIGH);
        push_ticks(cmd_ticks(FUNC_START), SDA_HIGH);
        push_cmd(FUNC_WRITE, 8'hFF, MODE_ADDR_W, SDA_LOW, 0);
        push_cmd(FUNC_WRITE, 8'h00, MODE_ADDR_R, SDA_HIGH, 0);
        push_cmd(FUNC_WRITE, 8'hA5, MODE_RAW, SDA_RANDOM, 0);
        push_cmd(FUNC_WRITE, 8'h5A, 2'd3, SDA_RANDOM, 0);
        push_cmd(FUNC_READ, 8'h00, MODE_RAW, SDA_HIGH, 0);
        push_cmd(FUNC_READ, 8'hFF, MODE_ADDR_W, SDA_LOW, 0);
        push_cmd(FUNC_READ, 8'h3C, 2'd3, SDA_RANDOM, 0);
        push_cmd(FUNC_STOP, 8'h00, MODE_RAW, SDA_RANDOM, 0);
        // write and read with no start before them
        push_cmd(FUNC_WRITE, 8'h00, MODE_RAW, SDA_RANDOM, 0);
        push_cmd(FUNC_READ, 8'h00, MODE_ADDR_R, SDA_RANDOM, 0);
        push_request(FUNC_TICK, 8'h00, MODE_RAW, SDA_HIGH);
        settle();

        run_phase(PROF_ZERO, 40);
        run_phase(PROF_MIN, 40);
        run_phase(PROF_LONG_BUS, 0);
        no_idle = 1'b1;
        run_phase(PROF_SMALL, 1);

        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #60000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
